// ===== hw/rtl/page_bitmap_allocator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// page bitmap allocator assertion macros
// shared wrappers for clocked assertions, sampled on clk, off during rst
// ----------------------------------------------------------------------------
`ifndef PAGE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define PBAL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBAL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pbal_pkg.sv =====
// ----------------------------------------------------------------------------
// pbal_pkg
// beat types, command codes and status codes of the page bitmap allocator
// ----------------------------------------------------------------------------
package pbal_pkg;

  // command codes
  localparam logic [2:0] ACT_ALLOC  = 3'd0;
  localparam logic [2:0] ACT_FREE   = 3'd1;
  localparam logic [2:0] ACT_CONTIG = 3'd2;
  localparam logic [2:0] ACT_MFREE  = 3'd3;
  localparam logic [2:0] ACT_MUSED  = 3'd4;
  localparam logic [2:0] ACT_FILL   = 3'd5;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;

  // bitmap word holds this many page bits
  localparam int WORD_BITS = 32;
  localparam int PAGE_SHIFT = 12;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] address;
    logic [31:0] region_length;
    logic [15:0] page_count;
    logic [15:0] page_align;
  } req_t;

  typedef struct packed {
    logic [26:0] phys_addr;
    logic [1:0]  status;
  } rsp_t;

endpackage

// ===== hw/rtl/pbal_ram.sv =====
// ----------------------------------------------------------------------------
// pbal_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pbal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/page_bitmap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// page_bitmap_allocator_unit
// physical page allocator: one used bit per 4 KiB page plus a next-fit hint
// ----------------------------------------------------------------------------
// Commands arrive on req (valid/ready), one response beat per command leaves
// on rsp (valid/ready). req_ready is high only while the sequencer is idle;
// a finished response sits in the rsp register, so a new command is taken
// while the previous response still waits for rsp_ready.
// The bitmap lives in one ram of PAGE_TOTAL/32 words of 32 bits; every step
// goes through its single registered read port.
// Free page and region marks read and rewrite each bitmap word touched;
// fill-all-used writes every word. Single-page allocation reads and checks
// one word per step of the scan. Contiguous allocation runs a bound check on
// each candidate and visits the run one word segment at a time; each used
// page hit goes through the serial alignment divider and a multiply step
// (neither when the alignment is one), then each word of the run is marked.
// After reset the block sweeps the ram to all ones with req_ready low. A
// stalled rsp holds its beat and the sequencer waits in its done state until
// the register frees. PAGE_TOTAL must be a power of two.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_unit #(
  parameter int PAGE_TOTAL = 32768
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  pbal_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output pbal_pkg::rsp_t rsp
);
  import pbal_pkg::*;

  localparam int PB    = $clog2(PAGE_TOTAL);
  localparam int PW    = PB + 1;
  localparam int DEPTH = PAGE_TOTAL / WORD_BITS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = ((PW > 16) ? PW : 16) + 1;
  localparam int NW    = CW + 1;
  localparam int DCW   = $clog2(NW + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FILL = 4'd1;
  localparam logic [3:0] S_SRD  = 4'd2;
  localparam logic [3:0] S_SEV  = 4'd3;
  localparam logic [3:0] S_RRD  = 4'd4;
  localparam logic [3:0] S_RWR  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_CCHK = 4'd8;
  localparam logic [3:0] S_CRD  = 4'd9;
  localparam logic [3:0] S_CLD  = 4'd10;
  localparam logic [3:0] S_CEV  = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  // mask of bits of word w whose page lies in [lo, hi)
  function automatic logic [WORD_BITS-1:0] wmask(input logic [AW-1:0] w,
                                                 input logic [CW:0] lo,
                                                 input logic [CW:0] hi);
    logic [WORD_BITS-1:0] m;
    logic [CW:0]          pg;
    m = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      pg   = (CW+1)'({w, 5'(b)});
      m[b] = (pg >= lo) && (pg < hi);
    end
    return m;
  endfunction

  // index of lowest set bit
  function automatic logic [4:0] lowest(input logic [WORD_BITS-1:0] v);
    logic [4:0] r;
    r = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (v[b]) r = 5'(b);
    end
    return r;
  endfunction

  logic [3:0]           state;
  logic [PW-1:0]        hint;
  logic                 fill_reply;
  logic [AW-1:0]        wptr;
  logic [AW-1:0]        wlast;
  logic                 phase;
  logic [CW:0]          slo, shi;
  logic [CW:0]          rlo, rhi;
  logic                 rset;
  logic [PW-1:0]        res_page;
  logic [1:0]           res_st;
  logic [PW-1:0]        hint0;
  logic [CW-1:0]        c;
  logic [PW-1:0]        p;
  logic [15:0]          cn, cal;
  logic [PW-1:0]        climit;
  logic [AW-1:0]        bw;
  logic                 bv;
  logic [WORD_BITS-1:0] wbuf;
  logic [NW-1:0]        dnum, dquo;
  logic [15:0]          drem;
  logic [DCW-1:0]       dcnt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  pbal_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // request decode
  logic [PW-1:0]  h_fix;
  logic [15:0]    req_al;
  logic           free_bad;
  logic [32:0]    reg_end;
  logic [33:0]    reg_hi34;
  logic [21:0]    reg_hi22, reg_hic, reg_lo22, reg_last22;
  logic           reg_empty;

  assign h_fix  = (hint == '0) ? PW'(1) : hint;
  assign req_al = (req.page_align == '0) ? 16'd1 : req.page_align;
  assign free_bad = (req.address[11:0] != '0) || (req.address[31:12] == '0)
                    || ({12'b0, req.address[31:12]} >= 32'(PAGE_TOTAL));

  always_comb begin
    reg_end  = {1'b0, req.address} + {1'b0, req.region_length};
    reg_hi34 = {1'b0, reg_end} + 34'hFFF;
    reg_hi22 = reg_hi34[33:12];
    reg_hic  = (reg_hi22 > 22'(PAGE_TOTAL)) ? 22'(PAGE_TOTAL) : reg_hi22;
    reg_lo22 = {2'b0, req.address[31:12]};
    if (req.action == ACT_MFREE && reg_lo22 == '0) reg_lo22 = 22'd1;
    reg_last22 = reg_hic - 22'd1;
    reg_empty  = (req.region_length == '0) || (reg_lo22 >= reg_hic);
  end

  // single-page scan evaluation
  logic [WORD_BITS-1:0] sev_free;
  logic [PW-1:0]        sev_page;
  assign sev_free = ~ram_rdata & wmask(wptr, slo, shi);
  assign sev_page = PW'({wptr, lowest(sev_free)});

  // range update evaluation
  logic [WORD_BITS-1:0] rwr_mask;
  assign rwr_mask = wmask(wptr, rlo, rhi);

  // contiguous run evaluation
  logic [CW:0]          cev_run_end, cev_wend, cev_e, cev_last;
  logic [WORD_BITS-1:0] cev_used;
  logic [CW-1:0]        cev_x;
  always_comb begin
    cev_run_end = (CW+1)'(c) + (CW+1)'(cn);
    cev_last    = cev_run_end - (CW+1)'(1);
    cev_wend    = (CW+1)'({bw, 5'b0}) + (CW+1)'(WORD_BITS);
    cev_e       = (cev_wend < cev_run_end) ? cev_wend : cev_run_end;
    cev_used    = wbuf & wmask(bw, (CW+1)'(p), cev_e);
    cev_x       = CW'({bw, lowest(cev_used)}) + CW'(1);
  end

  // divider step
  logic [16:0] div_sh;
  logic        div_ge;
  assign div_sh = {drem, dnum[NW-1]};
  assign div_ge = div_sh >= {1'b0, cal};

  // ram port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wptr;
    ram_wdata = '1;
    ram_raddr = (state == S_CRD) ? p[AW+4:5] : wptr;
    case (state)
      S_FILL: ram_we = 1'b1;
      S_SEV: begin
        ram_we    = |sev_free;
        ram_wdata = ram_rdata | (WORD_BITS'(1) << lowest(sev_free));
      end
      S_RWR: begin
        ram_we    = 1'b1;
        ram_wdata = rset ? (ram_rdata | rwr_mask) : (ram_rdata & ~rwr_mask);
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign req_ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      wptr       <= '0;
      hint       <= PW'(1);
      fill_reply <= 1'b0;
      bv         <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      // the done state reloads the register itself
      if (rsp_valid && rsp_ready && state != S_DONE) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            res_page <= '0;
            bv       <= 1'b0;
            case (req.action)
              ACT_ALLOC: begin
                if (h_fix < PW'(PAGE_TOTAL)) begin
                  res_st <= ST_DONE;
                  phase  <= 1'b0;
                  slo    <= (CW+1)'(h_fix);
                  shi    <= (CW+1)'(PAGE_TOTAL);
                  wptr   <= h_fix[AW+4:5];
                  wlast  <= AW'(DEPTH - 1);
                  state  <= S_SRD;
                end else if (h_fix > PW'(1)) begin
                  res_st <= ST_DONE;
                  phase  <= 1'b1;
                  slo    <= (CW+1)'(1);
                  shi    <= (CW+1)'(h_fix);
                  wptr   <= '0;
                  wlast  <= AW'((h_fix - PW'(1)) >> 5);
                  state  <= S_SRD;
                end else begin
                  res_st <= ST_NOSPACE;
                  hint   <= h_fix;
                  state  <= S_DONE;
                end
              end
              ACT_FREE: begin
                if (free_bad) begin
                  res_st <= ST_REJECT;
                  state  <= S_DONE;
                end else begin
                  res_st <= ST_DONE;
                  rlo    <= (CW+1)'(req.address[31:12]);
                  rhi    <= (CW+1)'(req.address[31:12]) + (CW+1)'(1);
                  rset   <= 1'b0;
                  wptr   <= AW'(req.address[31:17]);
                  wlast  <= AW'(req.address[31:17]);
                  if (PW'(req.address[31:12]) < hint) hint <= PW'(req.address[31:12]);
                  state  <= S_RRD;
                end
              end
              ACT_CONTIG: begin
                if (req.page_count == '0) begin
                  res_st <= ST_REJECT;
                  state  <= S_DONE;
                end else begin
                  res_st <= ST_DONE;
                  phase  <= 1'b0;
                  cn     <= req.page_count;
                  cal    <= req_al;
                  hint0  <= h_fix;
                  climit <= PW'(PAGE_TOTAL);
                  if (req_al == 16'd1) begin
                    c     <= CW'(h_fix);
                    state <= S_CCHK;
                  end else begin
                    dnum  <= NW'(h_fix) + NW'(req_al) - NW'(1);
                    dquo  <= '0;
                    drem  <= '0;
                    dcnt  <= DCW'(NW);
                    state <= S_DIV;
                  end
                end
              end
              ACT_MFREE, ACT_MUSED: begin
                res_st <= ST_DONE;
                if (!reg_empty) begin
                  rlo   <= (CW+1)'(reg_lo22);
                  rhi   <= (CW+1)'(reg_hic);
                  rset  <= (req.action == ACT_MUSED);
                  wptr  <= AW'(reg_lo22 >> 5);
                  wlast <= AW'(reg_last22 >> 5);
                  state <= S_RRD;
                end else begin
                  state <= S_DONE;
                end
              end
              ACT_FILL: begin
                res_st     <= ST_DONE;
                wptr       <= '0;
                fill_reply <= 1'b1;
                state      <= S_FILL;
              end
              default: begin
                res_st <= ST_REJECT;
                state  <= S_DONE;
              end
            endcase
          end
        end

        // sweep every word to all ones
        S_FILL: begin
          wptr <= wptr + AW'(1);
          if (wptr == AW'(DEPTH - 1)) begin
            state      <= fill_reply ? S_DONE : S_IDLE;
            fill_reply <= 1'b0;
          end
        end

        // single-page scan
        S_SRD: state <= S_SEV;
        S_SEV: begin
          if (|sev_free) begin
            res_page <= sev_page;
            hint     <= sev_page + PW'(1);
            state    <= S_DONE;
          end else if (wptr != wlast) begin
            wptr  <= wptr + AW'(1);
            state <= S_SRD;
          end else if (!phase && h_fix > PW'(1)) begin
            phase <= 1'b1;
            slo   <= (CW+1)'(1);
            shi   <= (CW+1)'(h_fix);
            wptr  <= '0;
            wlast <= AW'((h_fix - PW'(1)) >> 5);
            state <= S_SRD;
          end else begin
            res_st <= ST_NOSPACE;
            hint   <= h_fix;
            state  <= S_DONE;
          end
        end

        // read-modify-write over a page range
        S_RRD: state <= S_RWR;
        S_RWR: begin
          if (wptr == wlast) begin
            state <= S_DONE;
          end else begin
            wptr  <= wptr + AW'(1);
            state <= S_RRD;
          end
        end

        // round candidate up to the alignment, one quotient bit a cycle
        S_DIV: begin
          drem <= div_ge ? 16'(div_sh - {1'b0, cal}) : div_sh[15:0];
          dquo <= {dquo[NW-2:0], div_ge};
          dnum <= dnum << 1;
          dcnt <= dcnt - DCW'(1);
          if (dcnt == DCW'(1)) state <= S_MUL;
        end
        S_MUL: begin
          c     <= CW'(dquo * cal);
          state <= S_CCHK;
        end

        // candidate bound check, wrap pass on overrun
        S_CCHK: begin
          if (cev_run_end > (CW+1)'(climit)) begin
            if (!phase) begin
              phase  <= 1'b1;
              c      <= CW'(cal);
              climit <= hint0;
            end else begin
              res_st <= ST_NOSPACE;
              state  <= S_DONE;
            end
          end else begin
            p     <= PW'(c);
            state <= S_CRD;
          end
        end

        // fetch the word under p unless already buffered
        S_CRD: begin
          if (bv && bw == p[AW+4:5]) state <= S_CEV;
          else state <= S_CLD;
        end
        S_CLD: begin
          wbuf  <= ram_rdata;
          bw    <= p[AW+4:5];
          bv    <= 1'b1;
          state <= S_CEV;
        end

        // check the run segment inside the buffered word
        S_CEV: begin
          if (cev_used == '0) begin
            if (cev_e == cev_run_end) begin
              res_page <= PW'(c);
              hint     <= PW'(cev_run_end);
              rlo      <= (CW+1)'(c);
              rhi      <= cev_run_end;
              rset     <= 1'b1;
              wptr     <= AW'(c >> 5);
              wlast    <= AW'(cev_last >> 5);
              state    <= S_RRD;
            end else begin
              p     <= PW'(cev_e);
              state <= S_CRD;
            end
          end else if (cal == 16'd1) begin
            c     <= cev_x;
            state <= S_CCHK;
          end else begin
            dnum  <= NW'(cev_x) + NW'(cal) - NW'(1);
            dquo  <= '0;
            drem  <= '0;
            dcnt  <= DCW'(NW);
            state <= S_DIV;
          end
        end

        // hand the beat to the response register
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid     <= 1'b1;
            rsp.phys_addr <= 27'({res_page, 12'b0});
            rsp.status    <= res_st;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/pbal_chk.sv =====
// ----------------------------------------------------------------------------
// pbal_chk
// port-level checks of the page bitmap allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "page_bitmap_allocator_unit_assert.svh"

module pbal_chk (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input pbal_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input pbal_pkg::rsp_t rsp
);
  import pbal_pkg::*;

  // stalled response beat holds
  `PBAL_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp changed while stalled")

  // a failed command never carries an address
  `PBAL_ASSERT_IMP(a_fail_zero, rsp_valid && rsp.status != ST_DONE, rsp.phys_addr == '0, "failure with address")

  // addresses are page aligned
  `PBAL_ASSERT_IMP(a_page_align, rsp_valid, rsp.phys_addr[11:0] == '0, "unaligned address")

  // a taken command drops req_ready in the next cycle
  `PBAL_ASSERT_NXT(a_busy, req_valid && req_ready, !req_ready, "ready right after accept")

endmodule

bind page_bitmap_allocator_unit pbal_chk u_pbal_chk (.*);

// ===== test/pbal_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pbal_checker
// watches both channels of the page allocator, predicts every response from
// its own copy of the bitmap and hint, and counts mismatches
// ----------------------------------------------------------------------------
module pbal_checker #(
  parameter int PAGE_TOTAL = 32768
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  pbal_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  pbal_pkg::rsp_t rsp,
  output int             errors,
  output int             pending
);
  import pbal_pkg::*;

  // shadow allocator state
  logic              page_used_map [PAGE_TOTAL];
  longint unsigned   fit_hint;
  rsp_t              rsp_due [$];

  function automatic logic page_taken(longint unsigned p);
    if (p >= PAGE_TOTAL) return 1'b1;
    return page_used_map[p];
  endfunction

  function automatic void fill_map();
    for (int p = 0; p < PAGE_TOTAL; p++) page_used_map[p] = 1'b1;
  endfunction

  // aligned first fit, skipping past the first used page of a candidate
  function automatic longint unsigned first_aligned_run(longint unsigned i,
      longint unsigned limit, longint unsigned aln, longint unsigned n);
    longint unsigned j;
    while (i + n <= limit) begin
      for (j = 0; j < n; j++) if (page_taken(i + j)) break;
      if (j == n) return i;
      i += aln * ((j + aln) / aln);
    end
    return 0;
  endfunction

  // one command against the shadow state
  function automatic rsp_t alloc_outcome(req_t b);
    rsp_t            r;
    longint unsigned h, found, aln, cnt, first, lo, hi, pg;
    r.phys_addr = '0;
    r.status    = ST_DONE;
    found = 0;
    case (b.action)
      ACT_ALLOC: begin
        h = (fit_hint == 0) ? 64'd1 : fit_hint;
        for (pg = h; pg < PAGE_TOTAL && found == 0; pg++)
          if (!page_taken(pg)) found = pg;
        for (pg = 1; pg < h && found == 0; pg++)
          if (!page_taken(pg)) found = pg;
        if (found != 0) begin
          page_used_map[found] = 1'b1;
          fit_hint    = found + 1;
          r.phys_addr = 27'(found << PAGE_SHIFT);
        end else begin
          fit_hint = h;
          r.status = ST_NOSPACE;
        end
      end
      ACT_FREE: begin
        pg = 64'(b.address >> PAGE_SHIFT);
        if (b.address[11:0] != 0 || pg == 0 || pg >= PAGE_TOTAL) begin
          r.status = ST_REJECT;
        end else begin
          page_used_map[pg] = 1'b0;
          if (pg < fit_hint) fit_hint = pg;
        end
      end
      ACT_CONTIG: begin
        cnt = 64'(b.page_count);
        aln = (b.page_align == '0) ? 64'd1 : 64'(b.page_align);
        if (cnt == 0) begin
          r.status = ST_REJECT;
        end else begin
          h     = (fit_hint == 0) ? 64'd1 : fit_hint;
          first = ((h + aln - 1) / aln) * aln;
          found = first_aligned_run(first, PAGE_TOTAL, aln, cnt);
          // wrap pass: must end at or below the old hint
          if (found == 0) found = first_aligned_run(aln, h, aln, cnt);
          if (found != 0) begin
            for (pg = found; pg < found + cnt; pg++) page_used_map[pg] = 1'b1;
            fit_hint    = found + cnt;
            r.phys_addr = 27'(found << PAGE_SHIFT);
          end else begin
            r.status = ST_NOSPACE;
          end
        end
      end
      ACT_MFREE, ACT_MUSED: begin
        if (b.region_length != 0) begin
          lo = 64'(b.address >> PAGE_SHIFT);
          hi = (64'(b.address) + 64'(b.region_length) + 64'hFFF) >> PAGE_SHIFT;
          if (hi > PAGE_TOTAL) hi = 64'(PAGE_TOTAL);
          for (pg = lo; pg < hi; pg++) begin
            if (b.action == ACT_MUSED) page_used_map[pg] = 1'b1;
            else if (pg != 0) page_used_map[pg] = 1'b0;
          end
        end
      end
      ACT_FILL: fill_map();
      default: r.status = ST_REJECT;
    endcase
    return r;
  endfunction

  // predict on accepted commands, compare accepted responses
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      fill_map();
      fit_hint = 1;
      rsp_due.delete();
      errors = 0;
    end else begin
      if (req_valid && req_ready) rsp_due.push_back(alloc_outcome(req));
      if (rsp_valid && rsp_ready) begin
        if (rsp_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected response addr=%h status=%0d",
                     $realtime, rsp.phys_addr, rsp.status);
        end else begin
          want = rsp_due.pop_front();
          if (want.phys_addr !== rsp.phys_addr || want.status !== rsp.status) begin
            errors++;
            if (errors <= 10)
              $display("%0t: response mismatch: expected addr=%h status=%0d, got addr=%h status=%0d",
                       $realtime, want.phys_addr, want.status, rsp.phys_addr, rsp.status);
          end
        end
      end
    end
    pending = rsp_due.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives directed and random allocator commands with random gaps and
// response stalls; a checker beside the block predicts every response
// ----------------------------------------------------------------------------
module tb_top;
  import pbal_pkg::*;

  localparam int PAGE_TOTAL = 32768;
  localparam logic [2:0] ACT_BAD_LO = 3'd6;
  localparam logic [2:0] ACT_BAD_HI = 3'd7;
  localparam int RANDOM_BEATS = 1600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  int   errors;
  int   pending;

  int   beats_sent = 0;
  bit   burst = 1'b0;
  bit   hold_rsp = 1'b0;
  bit   rsp_fire = 1'b0;
  int   rsp_wait = 0;

  always #5 clk = ~clk;

  page_bitmap_allocator_unit #(.PAGE_TOTAL(PAGE_TOTAL)) dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  pbal_checker #(.PAGE_TOTAL(PAGE_TOTAL)) u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .errors(errors), .pending(pending)
  );

  // response side: random stall per beat, plus a long hold-off
  always @(posedge clk) rsp_fire = rsp_valid && rsp_ready;

  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_fire) rsp_wait = burst ? 0 : $urandom_range(0, 13);
      if (rsp_wait > 0) begin
        rsp_wait--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= !hold_rsp;
      end
    end
  end

  initial begin
    wait (beats_sent >= 300);
    hold_rsp = 1'b1;
    repeat (400) @(negedge clk);
    hold_rsp = 1'b0;
  end

  // count and alignment keep their low 16 bits
  function automatic req_t cmd(logic [2:0] act, logic [31:0] addr, logic [31:0] len,
                               logic [31:0] cnt, logic [31:0] aln);
    req_t b;
    b.action        = act;
    b.address       = addr;
    b.region_length = len;
    b.page_count    = cnt[15:0];
    b.page_align    = aln[15:0];
    return b;
  endfunction

  // one command beat, held until taken
  task automatic send(input req_t b);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= b;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic send_random();
    int          pick;
    logic [31:0] addr;
    logic [31:0] cnt;
    logic [31:0] aln;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      send(cmd(ACT_ALLOC, $urandom, $urandom, $urandom, $urandom));
    end else if (pick < 45) begin
      addr = ($urandom_range(0, 99) < 85) ? ($urandom_range(1, 2047) << PAGE_SHIFT)
                                          : $urandom;
      send(cmd(ACT_FREE, addr, $urandom, $urandom, $urandom));
    end else if (pick < 67) begin
      cnt = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 64);
      case ($urandom_range(0, 5))
        0: aln = 0;
        1: aln = 1;
        2: aln = 32'd1 << $urandom_range(1, 6);
        3: aln = $urandom_range(2, 40);
        4: aln = $urandom;
        default: aln = 1;
      endcase
      send(cmd(ACT_CONTIG, $urandom, $urandom, cnt, aln));
    end else if (pick < 77) begin
      if ($urandom_range(0, 3) == 0)
        send(cmd(ACT_MFREE, $urandom, $urandom, $urandom, $urandom));
      else
        send(cmd(ACT_MFREE, $urandom_range(0, 32'h0100_0000),
                 $urandom_range(0, 32'h0004_0000), $urandom, $urandom));
    end else if (pick < 88) begin
      // wide marks only above the top, so the map stays mostly open
      if ($urandom_range(0, 3) == 0)
        send(cmd(ACT_MUSED, $urandom | 32'h0800_0000, $urandom, $urandom, $urandom));
      else
        send(cmd(ACT_MUSED, $urandom_range(0, 32'h0800_0000),
                 $urandom_range(0, 32'h0002_0000), $urandom, $urandom));
    end else if (pick < 91) begin
      send(cmd(ACT_FILL, $urandom, $urandom, $urandom, $urandom));
      send(cmd(ACT_MFREE, 0, 32'h0800_0000, 0, 0));
    end else if (pick < 94) begin
      send(cmd(($urandom_range(0, 1) != 0) ? ACT_BAD_HI : ACT_BAD_LO,
               $urandom, $urandom, $urandom, $urandom));
    end else begin
      send(cmd(ACT_MFREE, 0, 32'h0800_0000, 0, 0));
    end
  endtask

  // stimulus and verdict
  initial begin
    int waited;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // directed: full map after reset
    send(cmd(ACT_ALLOC, 0, 0, 0, 0));
    send(cmd(ACT_CONTIG, 0, 0, 1, 0));
    send(cmd(ACT_CONTIG, 0, 0, 1, 32'h0000_4000));
    send(cmd(ACT_FREE, 32'h0000_1001, 0, 0, 0));
    send(cmd(ACT_FREE, 32'h0000_0000, 0, 0, 0));
    send(cmd(ACT_FREE, 32'h0800_0000, 0, 0, 0));
    send(cmd(ACT_FREE, 32'hFFFF_F000, 0, 0, 0));
    send(cmd(ACT_CONTIG, 0, 0, 0, 4));
    send(cmd(ACT_BAD_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_FFFF));
    send(cmd(ACT_BAD_HI, 0, 0, 0, 0));
    send(cmd(ACT_MFREE, 32'h0000_2000, 0, 0, 0));
    // open the whole map; page zero stays used
    send(cmd(ACT_MFREE, 0, 32'h0800_0000, 0, 0));
    send(cmd(ACT_ALLOC, 0, 0, 0, 0));
    send(cmd(ACT_FREE, 32'h0000_1000, 0, 0, 0));
    send(cmd(ACT_ALLOC, 0, 0, 0, 0));
    send(cmd(ACT_CONTIG, 0, 0, 8, 0));
    send(cmd(ACT_CONTIG, 0, 0, 4, 16));
    send(cmd(ACT_CONTIG, 0, 0, 32'h0000_8000, 1));
    send(cmd(ACT_CONTIG, 0, 0, 1, 32'h0000_FFFF));
    send(cmd(ACT_MUSED, 0, 1, 0, 0));
    send(cmd(ACT_MUSED, 32'hFFFF_F000, 32'hFFFF_FFFF, 0, 0));
    send(cmd(ACT_MFREE, 32'h0100_0000, 32'hFFFF_FFFF, 0, 0));
    send(cmd(ACT_FILL, 0, 0, 0, 0));
    send(cmd(ACT_MFREE, 0, 32'h0800_0000, 0, 0));
    send(cmd(ACT_ALLOC, 0, 0, 0, 0));

    // random phases, each picked at random between gaps and back-to-back beats
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 100 == 0) burst = ($urandom_range(0, 2) == 0);
      if (n == 800) begin
        req_valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        @(negedge clk);
      end
      send_random();
    end
    req_valid <= 1'b0;

    // drain
    waited = 0;
    while (pending != 0 && waited < 500000) begin
      @(negedge clk);
      waited++;
    end
    repeat (200) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
